// ===== hdl/pfnc_pkg.sv =====
package pfnc_pkg;

   // fade depth and fixed-point format
   localparam int SHADE_LEVELS = 32;
   localparam int FADE_EXTRA   = 8;
   localparam int FADE_DIV     = SHADE_LEVELS + FADE_EXTRA;
   localparam int FRAC_BITS    = 16;

   // palette geometry
   localparam int PAL_DEPTH = 256;
   localparam int IDX_W     = $clog2(PAL_DEPTH);
   localparam int COMP_W    = 8;
   localparam int LEVEL_W   = 6;

   // squared distance of three components
   localparam int SQ_W   = 2 * COMP_W;
   localparam int DIST_W = SQ_W + 2;

   // step quotient and fade accumulators
   localparam int QUO_W     = COMP_W + FRAC_BITS;
   localparam int STEP_W    = QUO_W + 1;
   localparam int ACC_W     = QUO_W + 2;

   // rounded-up reciprocal of the step divisor, exact for any QUO_W-bit dividend
   localparam int     RECIP_SHIFT = QUO_W + $clog2(FADE_DIV);
   localparam int     RECIP_W     = QUO_W + 1;
   localparam longint RECIP_VAL   =
      ((longint'(1) << RECIP_SHIFT) + longint'(FADE_DIV) - 1) / longint'(FADE_DIV);
   localparam int     PROD_W      = COMP_W + RECIP_W;
   localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_VAL);

   // register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = COMP_W;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_FADE   = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_RED   = 2'd0,
      CSR_TARGET_GREEN = 2'd1,
      CSR_TARGET_BLUE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      rgb_type          data;
   } pal_wr_type;

   typedef struct packed {
      logic    start;
      rgb_type query;
   } scan_cmd_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] best;
   } scan_stat_type;

   typedef struct packed {
      logic              start;
      logic [COMP_W:0]   diff;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [STEP_W-1:0] step;
   } div_stat_type;

endpackage

// ===== hdl/pfnc_channels.sv =====
interface pfnc_req_if;
   import pfnc_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [IDX_W-1:0]  index;
   logic [COMP_W-1:0] red;
   logic [COMP_W-1:0] green;
   logic [COMP_W-1:0] blue;

   modport source (output valid, output cmd, output index, output red, output green,
                   output blue, input ready);
   modport sink (input valid, input cmd, input index, input red, input green,
                 input blue, output ready);
endinterface

interface pfnc_rsp_if;
   import pfnc_pkg::*;

   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   color;
   logic [LEVEL_W-1:0] shade_level;
   logic               last;

   modport source (output valid, output color, output shade_level, output last,
                   input ready);
   modport sink (input valid, input color, input shade_level, input last,
                 output ready);
endinterface

// ===== hdl/palette_fade_nearest_color.sv =====
// write request: stays idle, the next request is taken in the following cycle
// lookup request: a scan of every palette entry plus start, pipeline and handoff; the
//   result loads the output register, and the next request is taken once it is handed over
// fade request: entry fetch and a step multiply per component, then SHADE_LEVELS scans
//   like the lookup one, a stalled output adds to each handoff
// reset (synchronous, active high) clears control and targets; palette is not cleared
module palette_fade_nearest_color (
   input  logic                            clock,
   input  logic                            reset,
   pfnc_req_if.sink                        req_chan,
   pfnc_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [pfnc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfnc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pfnc_pkg::*;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SCAN_START,
      ST_SCAN_WAIT,
      ST_PUSH
   } state_type;

   // component being divided
   typedef enum logic [1:0] {
      COMP_RED,
      COMP_GREEN,
      COMP_BLUE
   } comp_type;

   state_type           state_ff;
   comp_type            comp_ff;
   logic                fade_ff;
   logic [IDX_W-1:0]    src_idx_ff;
   rgb_type             query_ff;
   rgb_type             src_ff;
   rgb_type             tgt_ff;
   logic [LEVEL_W-1:0]  level_ff;

   logic signed [ACC_W-1:0]  acc_r_ff, acc_g_ff, acc_b_ff;
   logic signed [STEP_W-1:0] step_r_ff, step_g_ff, step_b_ff;

   // output register
   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    color_ff;
   logic [LEVEL_W-1:0]  shade_ff;
   logic                last_ff;

   logic                req_fire;
   logic                push_ok;
   logic                push_fire;
   logic                level_last;
   rgb_type             fade_rgb;
   logic [COMP_W-1:0]   src_c, tgt_c;

   pal_wr_type          pal_wr;
   scan_cmd_type        scan_cmd;
   scan_stat_type       scan_stat;
   rgb_type             rd_data;
   div_cmd_type         div_cmd;
   div_stat_type        div_stat;

   // integer part of a fade accumulator, clamped at zero
   function automatic logic [COMP_W-1:0] acc_comp(input logic signed [ACC_W-1:0] acc);
      begin
         acc_comp = acc[ACC_W-1] ? '0 : acc[FRAC_BITS +: COMP_W];
      end
   endfunction

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == ST_IDLE);
   assign push_ok        = !rsp_valid_ff || rsp_chan.ready;
   assign push_fire      = (state_ff == ST_PUSH) && push_ok;
   assign level_last     = (level_ff == LEVEL_W'(SHADE_LEVELS - 1));

   assign fade_rgb.red   = acc_comp(acc_r_ff);
   assign fade_rgb.green = acc_comp(acc_g_ff);
   assign fade_rgb.blue  = acc_comp(acc_b_ff);

   // palette writes happen only while the sequencer is idle
   assign pal_wr.en   = req_fire && (req_chan.cmd == CMD_WRITE);
   assign pal_wr.addr = req_chan.index;
   assign pal_wr.data = {req_chan.red, req_chan.green, req_chan.blue};

   assign scan_cmd.start = (state_ff == ST_SCAN_START);
   assign scan_cmd.query = fade_ff ? fade_rgb : query_ff;

   // per-component operands for the step divider
   always_comb begin
      case (comp_ff)
         COMP_RED: begin
            src_c = src_ff.red;
            tgt_c = tgt_ff.red;
         end
         COMP_GREEN: begin
            src_c = src_ff.green;
            tgt_c = tgt_ff.green;
         end
         COMP_BLUE: begin
            src_c = src_ff.blue;
            tgt_c = tgt_ff.blue;
         end
         default: begin
            src_c = '0;
            tgt_c = '0;
         end
      endcase
   end

   assign div_cmd.start = (state_ff == ST_DIV_START);
   assign div_cmd.diff  = {1'b0, tgt_c} - {1'b0, src_c};

   pfnc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .wr         (pal_wr),
      .fetch_addr (src_idx_ff),
      .cmd        (scan_cmd),
      .rd_data    (rd_data),
      .stat       (scan_stat)
   );

   pfnc_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // target colour registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_RED:   tgt_ff.red   <= csr_wdata;
            CSR_TARGET_GREEN: tgt_ff.green <= csr_wdata;
            CSR_TARGET_BLUE:  tgt_ff.blue  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         comp_ff      <= COMP_RED;
         fade_ff      <= 1'b0;
      end else begin
         // a new result loads the output register, a taken one leaves it
         if (push_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_chan.cmd)
                     CMD_LOOKUP: begin
                        query_ff <= {req_chan.red, req_chan.green, req_chan.blue};
                        fade_ff  <= 1'b0;
                        level_ff <= '0;
                        state_ff <= ST_SCAN_START;
                     end
                     CMD_FADE: begin
                        src_idx_ff <= req_chan.index;
                        fade_ff    <= 1'b1;
                        state_ff   <= ST_FETCH;
                     end
                     default: ;
                  endcase
               end
            end

            // source entry is read this cycle
            ST_FETCH: begin
               state_ff <= ST_LOAD;
            end

            ST_LOAD: begin
               src_ff   <= rd_data;
               acc_r_ff <= ACC_W'({rd_data.red, {FRAC_BITS{1'b0}}});
               acc_g_ff <= ACC_W'({rd_data.green, {FRAC_BITS{1'b0}}});
               acc_b_ff <= ACC_W'({rd_data.blue, {FRAC_BITS{1'b0}}});
               comp_ff  <= COMP_RED;
               state_ff <= ST_DIV_START;
            end

            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end

            ST_DIV_WAIT: begin
               if (div_stat.done) begin
                  case (comp_ff)
                     COMP_RED: begin
                        step_r_ff <= div_stat.step;
                        comp_ff   <= COMP_GREEN;
                        state_ff  <= ST_DIV_START;
                     end
                     COMP_GREEN: begin
                        step_g_ff <= div_stat.step;
                        comp_ff   <= COMP_BLUE;
                        state_ff  <= ST_DIV_START;
                     end
                     default: begin
                        step_b_ff <= div_stat.step;
                        level_ff  <= '0;
                        state_ff  <= ST_SCAN_START;
                     end
                  endcase
               end
            end

            ST_SCAN_START: begin
               state_ff <= ST_SCAN_WAIT;
            end

            ST_SCAN_WAIT: begin
               if (scan_stat.done) begin
                  state_ff <= ST_PUSH;
               end
            end

            // hand the result over, then step to the next shade level, or go idle after a lookup or the last level
            ST_PUSH: begin
               if (push_ok) begin
                  color_ff     <= scan_stat.best;
                  shade_ff     <= level_ff;
                  last_ff      <= !fade_ff || level_last;
                  if (!fade_ff || level_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     acc_r_ff <= acc_r_ff + ACC_W'(step_r_ff);
                     acc_g_ff <= acc_g_ff + ACC_W'(step_g_ff);
                     acc_b_ff <= acc_b_ff + ACC_W'(step_b_ff);
                     level_ff <= level_ff + 1'b1;
                     state_ff <= ST_SCAN_START;
                  end
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.color       = color_ff;
   assign rsp_chan.shade_level = shade_ff;
   assign rsp_chan.last        = last_ff;

endmodule

// ===== hdl/pfnc_scan.sv =====
module pfnc_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  pfnc_pkg::pal_wr_type     wr,
   input  logic [pfnc_pkg::IDX_W-1:0] fetch_addr,
   input  pfnc_pkg::scan_cmd_type   cmd,
   output pfnc_pkg::rgb_type        rd_data,
   output pfnc_pkg::scan_stat_type  stat
);
   import pfnc_pkg::*;

   rgb_type mem [PAL_DEPTH];

   rgb_type            rd_ff;
   logic [IDX_W-1:0]   rd_addr;

   logic               busy_ff, busy_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   rgb_type            query_ff, query_in;

   logic               v1_ff, v1_in;
   logic [IDX_W-1:0]   idx1_ff, idx1_in;

   logic               v2_ff, v2_in;
   logic [IDX_W-1:0]   idx2_ff, idx2_in;
   logic [SQ_W-1:0]    sq_r_ff, sq_r_in;
   logic [SQ_W-1:0]    sq_g_ff, sq_g_in;
   logic [SQ_W-1:0]    sq_b_ff, sq_b_in;

   logic [DIST_W-1:0]  dist_sum;
   logic               take;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic               done_ff, done_in;

   function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                               input logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] d;
      begin
         d = (a > b) ? (a - b) : (b - a);
         sq_diff = SQ_W'(d) * SQ_W'(d);
      end
   endfunction

   assign rd_addr = busy_ff ? cnt_ff : fetch_addr;

   // single write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      query_in = query_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         query_in = cmd.query;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == IDX_W'(PAL_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end

      // stage 1: read data arrives
      v1_in   = busy_ff;
      idx1_in = cnt_ff;

      // stage 2: per-component squares
      v2_in   = v1_ff;
      idx2_in = idx1_ff;
      sq_r_in = sq_diff(query_ff.red, rd_ff.red);
      sq_g_in = sq_diff(query_ff.green, rd_ff.green);
      sq_b_in = sq_diff(query_ff.blue, rd_ff.blue);

      // stage 3: sum and keep the first strict minimum
      dist_sum = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
      take = v2_ff && ((idx2_ff == '0) || (dist_sum < best_dist_ff));
      best_dist_in = take ? dist_sum : best_dist_ff;
      best_in      = take ? idx2_ff : best_ff;
      done_in      = v2_ff && (idx2_ff == IDX_W'(PAL_DEPTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         done_ff <= done_in;
      end
      cnt_ff       <= cnt_in;
      query_ff     <= query_in;
      idx1_ff      <= idx1_in;
      idx2_ff      <= idx2_in;
      sq_r_ff      <= sq_r_in;
      sq_g_ff      <= sq_g_in;
      sq_b_ff      <= sq_b_in;
      best_dist_ff <= best_dist_in;
      best_ff      <= best_in;
   end

   assign rd_data   = rd_ff;
   assign stat.done = done_ff;
   assign stat.best = best_ff;

endmodule

// ===== hdl/pfnc_divider.sv =====
module pfnc_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  pfnc_pkg::div_cmd_type  cmd,
   output pfnc_pkg::div_stat_type stat
);
   import pfnc_pkg::*;

   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [COMP_W:0]      mag_full;
   logic [QUO_W-1:0]     quo;

   always_comb begin
      done_in  = cmd.start;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      mag_full = cmd.diff[COMP_W] ? (~cmd.diff + 1'b1) : cmd.diff;

      if (cmd.start) begin
         // magnitude times the reciprocal, the dividend's fraction bits fold into the shift
         neg_in  = cmd.diff[COMP_W];
         prod_in = PROD_W'(mag_full[COMP_W-1:0]) * RECIP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   assign quo = QUO_W'(prod_ff >> (RECIP_SHIFT - FRAC_BITS));

   // truncation toward zero: divide the magnitude, then restore the sign
   assign stat.done = done_ff;
   assign stat.step = neg_ff ? (~STEP_W'(quo) + 1'b1) : STEP_W'(quo);

endmodule

// ===== hdl/pfnc_checker.sv =====
module pfnc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_cmd,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pfnc_pkg::IDX_W-1:0]        rsp_color,
   input logic [pfnc_pkg::LEVEL_W-1:0]      rsp_shade_level,
   input logic                              rsp_last
);
   import pfnc_pkg::*;

   // no result shows right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color)
         && $stable(rsp_shade_level) && $stable(rsp_last))
      else $error("stalled result changed");

   // lookups and fades occupy the block
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_LOOKUP || req_cmd == CMD_FADE)
         |=> !req_ready)
      else $error("request taken while a search runs");

   // palette writes never stall the request side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_WRITE |=> req_ready)
      else $error("write request stalled the block");

   // a run ends on a lookup result or on the final shade level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         (rsp_shade_level == '0 || rsp_shade_level == LEVEL_W'(SHADE_LEVELS - 1)))
      else $error("last flag on an inner shade level");

endmodule

bind palette_fade_nearest_color pfnc_checker u_pfnc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_cmd         (req_chan.cmd),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_color       (rsp_chan.color),
   .rsp_shade_level (rsp_chan.shade_level),
   .rsp_last        (rsp_chan.last)
);
